// ----- src/heap_sort_records_macros.svh -----
// Assertion macros shared by the heap sort RTL.
`ifndef HEAP_SORT_RECORDS_MACROS_SVH
`define HEAP_SORT_RECORDS_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define HSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define HSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define HSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/hsr_pkg.sv -----
// Constants and record type for the heap sort block.
package hsr_pkg;

  localparam int MaxRecords = 64;
  localparam int AddrW      = $clog2(MaxRecords);
  localparam int CntW       = $clog2(MaxRecords + 1);
  localparam int KeyW       = 32;
  localparam int PayW       = 32;
  localparam int RecW       = KeyW + PayW;

  typedef struct packed {
    logic [PayW-1:0]        payload;
    logic signed [KeyW-1:0] key;
  } rec_t;

endpackage

// ----- src/hsr_ram.sv -----
// Generic RAM: one write port, two registered read ports.
module hsr_ram #(
  parameter int Width = 64,
  parameter int Depth = 64,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  output logic [Width-1:0] rdata_a_o,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ----- src/heap_sort_records.sv -----
// Record heap sorter: load a set, heap-sort it in RAM, stream it out ascending.
//
//  port group  | dir | tdata (low bit up)              | tlast       | tuser
//  ------------+-----+---------------------------------+-------------+--------
//  s_axis      | in  | key[31:0], payload[63:32]       | is_final    | -
//  m_axis      | out | sorted_key[31:0], payload[63:32]| end_of_run  | dropped
//
// Loading takes one word per cycle until the word with tlast. The sort then runs
// from a single two-read RAM: each sift level reads both children, then compares
// and writes. Each result passes a RAM read and the output register, and holds
// while m_axis_tready_i is low.
// Reset is asynchronous and clears control only; the store is not cleared.
// Input is taken only while loading; words beyond capacity are dropped and flagged.
`include "heap_sort_records_macros.svh"

module heap_sort_records
  import hsr_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [RecW-1:0] s_axis_tdata_i,   // key [31:0], payload [63:32]
  input  logic            s_axis_tlast_i,   // is_final
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [RecW-1:0] m_axis_tdata_o,   // sorted_key [31:0], sorted_payload [63:32]
  output logic            m_axis_tlast_o,   // end_of_run
  output logic            m_axis_tuser_o    // dropped
);

  localparam logic [3:0] S_LOAD       = 4'd0;
  localparam logic [3:0] S_INIT       = 4'd1;
  localparam logic [3:0] S_SIFT_START = 4'd2;
  localparam logic [3:0] S_SIFT_ROOT  = 4'd3;
  localparam logic [3:0] S_SIFT_RD    = 4'd4;
  localparam logic [3:0] S_SIFT_CMP   = 4'd5;
  localparam logic [3:0] S_NEXT       = 4'd6;
  localparam logic [3:0] S_SWAP_RD    = 4'd7;
  localparam logic [3:0] S_SWAP_WR    = 4'd8;
  localparam logic [3:0] S_FIX        = 4'd9;
  localparam logic [3:0] S_EMIT_RD    = 4'd10;
  localparam logic [3:0] S_EMIT_LD    = 4'd11;
  localparam logic [3:0] S_EMIT_WAIT  = 4'd12;

  logic [3:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic            build_q, build_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [AddrW-1:0] last_q, last_d;
  logic [AddrW-1:0] r_q, r_d;
  rec_t            cur_q, cur_d;
  rec_t            out_q, out_d;
  logic            out_last_q, out_last_d;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  rec_t             ram_wdata;
  logic [AddrW-1:0] ram_ra, ram_rb;
  logic [RecW-1:0]  ram_rda, ram_rdb;
  rec_t             lrec, rrec;

  logic [AddrW:0] lc_w, rc_w;
  logic           sift_cont, lc_is_last;
  logic           cur_gt_l, cur_gt_r, l_gt_r;
  logic           s_fire;

  hsr_ram #(
    .Width(RecW),
    .Depth(MaxRecords)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr_a_i(ram_ra),
    .rdata_a_o(ram_rda),
    .raddr_b_i(ram_rb),
    .rdata_b_o(ram_rdb)
  );

  assign lrec = rec_t'(ram_rda);
  assign rrec = rec_t'(ram_rdb);

  // children of the sift position; continue while the left child is in range
  assign lc_w       = {r_q, 1'b1};
  assign rc_w       = lc_w + (AddrW+1)'(1);
  assign sift_cont  = lc_w <= {1'b0, last_q};
  assign lc_is_last = lc_w == {1'b0, last_q};
  assign cur_gt_l   = cur_q.key > lrec.key;
  assign cur_gt_r   = cur_q.key > rrec.key;
  assign l_gt_r     = lrec.key > rrec.key;

  assign s_axis_tready_o = state_q == S_LOAD;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = state_q == S_EMIT_WAIT;
  assign m_axis_tdata_o  = out_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = ovf_q;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    build_d    = build_q;
    idx_d      = idx_q;
    last_d     = last_q;
    r_d        = r_q;
    cur_d      = cur_q;
    out_d      = out_q;
    out_last_d = out_last_q;
    ram_we     = 1'b0;
    ram_waddr  = r_q;
    ram_wdata  = cur_q;
    ram_ra     = idx_q;
    ram_rb     = idx_q;

    case (state_q)
      S_LOAD: begin
        ram_waddr = count_q[AddrW-1:0];
        ram_wdata = rec_t'(s_axis_tdata_i);
        if (s_fire) begin
          if (count_q < CntW'(MaxRecords)) begin
            ram_we  = 1'b1;
            count_d = count_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast_i) begin
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        last_d = AddrW'(count_q - CntW'(1));
        if (count_q < CntW'(2)) begin
          idx_d   = AddrW'(count_q - CntW'(1));
          state_d = S_EMIT_RD;
        end else begin
          build_d = 1'b1;
          idx_d   = AddrW'((count_q - CntW'(2)) >> 1);
          state_d = S_SIFT_START;
        end
      end
      S_SIFT_START: begin
        ram_ra  = idx_q;
        r_d     = idx_q;
        state_d = S_SIFT_ROOT;
      end
      S_SIFT_ROOT: begin
        cur_d   = lrec;
        state_d = S_SIFT_RD;
      end
      S_SIFT_RD: begin
        if (sift_cont) begin
          ram_ra  = lc_w[AddrW-1:0];
          ram_rb  = rc_w[AddrW-1:0];
          state_d = S_SIFT_CMP;
        end else begin
          // drop the sifted record into its final slot
          ram_we  = 1'b1;
          state_d = S_NEXT;
        end
      end
      S_SIFT_CMP: begin
        ram_we = 1'b1;
        if (lc_is_last) begin
          if (cur_gt_l) begin
            ram_wdata = lrec;
            r_d       = lc_w[AddrW-1:0];
            state_d   = S_SIFT_RD;
          end else begin
            state_d = S_NEXT;
          end
        end else if (cur_gt_l && !l_gt_r) begin
          ram_wdata = lrec;
          r_d       = lc_w[AddrW-1:0];
          state_d   = S_SIFT_RD;
        end else if (cur_gt_r && l_gt_r) begin
          ram_wdata = rrec;
          r_d       = rc_w[AddrW-1:0];
          state_d   = S_SIFT_RD;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (build_q) begin
          if (idx_q != '0) begin
            idx_d   = idx_q - AddrW'(1);
            state_d = S_SIFT_START;
          end else begin
            build_d = 1'b0;
            idx_d   = AddrW'(count_q - CntW'(1));
            state_d = S_SWAP_RD;
          end
        end else begin
          idx_d   = idx_q - AddrW'(1);
          state_d = S_SWAP_RD;
        end
      end
      S_SWAP_RD: begin
        ram_ra  = '0;
        ram_rb  = idx_q;
        state_d = S_SWAP_WR;
      end
      S_SWAP_WR: begin
        // move the root to the tail, sift the old tail down from the root
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = lrec;
        cur_d     = rrec;
        r_d       = '0;
        if (idx_q == AddrW'(1)) begin
          state_d = S_FIX;
        end else begin
          last_d  = idx_q - AddrW'(1);
          state_d = S_SIFT_RD;
        end
      end
      S_FIX: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        idx_d     = AddrW'(count_q - CntW'(1));
        state_d   = S_EMIT_RD;
      end
      S_EMIT_RD: begin
        ram_ra  = idx_q;
        state_d = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        out_d      = lrec;
        out_last_d = idx_q == '0;
        state_d    = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        ram_ra = idx_q - AddrW'(1);
        if (m_axis_tready_i) begin
          if (out_last_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = S_LOAD;
          end else begin
            idx_d   = idx_q - AddrW'(1);
            state_d = S_EMIT_LD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      count_q    <= '0;
      ovf_q      <= 1'b0;
      build_q    <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      ovf_q      <= ovf_d;
      build_q    <= build_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    last_q <= last_d;
    r_q    <= r_d;
    cur_q  <= cur_d;
    out_q  <= out_d;
  end

  `HSR_ASSERT(a_no_overlap, !(s_axis_tready_o && m_axis_tvalid_o), "input and output both open")
  `HSR_ASSERT(a_count_cap, count_q <= CntW'(MaxRecords), "record count beyond capacity")
  `HSR_ASSERT_IMP(a_sift_range, state_q == S_SIFT_RD, r_q <= last_q, "sift slot past heap end")
  `HSR_ASSERT_IMP(a_emit_no_wr, state_q == S_EMIT_WAIT, !ram_we, "store written while emitting")
  `HSR_ASSERT_NXT(a_run_end, m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o, s_axis_tready_o && count_q == '0, "block not empty after run")

endmodule
